// File: rtl/msap_pkg.sv
package msap_pkg;

    localparam int DEPTH_DEFAULT       = 1024;
    localparam int VALUE_WIDTH_DEFAULT = 32;

    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 10;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 11;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE     = 2'd0,
        OP_PARTITION = 2'd1,
        OP_READ      = 2'd2,
        OP_NONE      = 2'd3
    } opcode_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [INDEX_W-1:0]  index;
        logic [VALUE_W-1:0]  value;
        logic                goes_left;
        logic [COUNT_W-1:0]  count;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic               read_goes_left;
        logic [COUNT_W-1:0] left_count;
    } out_item_t;

    // sequencer status seen by the top level
    typedef struct packed {
        logic busy;
        logic done;
    } sweep_stat_t;

endpackage

// File: rtl/msap_mem.sv
module msap_mem #(
    parameter int DEPTH = msap_pkg::DEPTH_DEFAULT,
    parameter int WIDTH = msap_pkg::VALUE_WIDTH_DEFAULT + 1
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/msap_sweep.sv
module msap_sweep #(
    parameter int DEPTH       = msap_pkg::DEPTH_DEFAULT,
    parameter int VALUE_WIDTH = msap_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [$clog2(DEPTH+1)-1:0]   n,
    input  logic [VALUE_WIDTH:0]         rd_data,
    output logic                         rd_en,
    output logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic                         wr_en,
    output logic [$clog2(DEPTH)-1:0]     wr_addr,
    output logic [VALUE_WIDTH:0]         wr_data,
    output logic [$clog2(DEPTH+1)-1:0]   left_count,
    output msap_pkg::sweep_stat_t        stat
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_COUNT  = 6'b000010,
        ST_SCAN_L = 6'b000100,
        ST_SCAN_R = 6'b001000,
        ST_SWAP   = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic                 rv_reg, rv_next;       // read issued last cycle
    logic [CW-1:0]        tag_reg, tag_next;     // address of that read
    logic [CW-1:0]        scan_reg, scan_next;
    logic [CW-1:0]        lo_reg, lo_next;
    logic [CW-1:0]        hi_reg, hi_next;
    logic [CW-1:0]        n_reg, n_next;
    logic [CW-1:0]        acc_reg, acc_next;
    logic [VALUE_WIDTH:0] lo_data_reg, lo_data_next;

    logic rd_class;
    assign rd_class = rd_data[VALUE_WIDTH];

    always_comb begin
        state_next   = state_reg;
        rv_next      = 1'b0;
        tag_next     = tag_reg;
        scan_next    = scan_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        n_next       = n_reg;
        acc_next     = acc_reg;
        lo_data_next = lo_data_reg;
        rd_en        = 1'b0;
        rd_addr      = AW'(scan_reg);
        wr_en        = 1'b0;
        wr_addr      = AW'(lo_reg);
        wr_data      = rd_data;

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    n_next    = n;
                    acc_next  = '0;
                    scan_next = '0;
                    state_next = (n == '0) ? ST_DONE : ST_COUNT;
                end
            end
            ST_COUNT: begin
                if (rv_reg) begin
                    acc_next = acc_reg + CW'(rd_class);
                end
                if (scan_reg < n_reg) begin
                    rd_en     = 1'b1;
                    rv_next   = 1'b1;
                    scan_next = scan_reg + 1'b1;
                end else if (!rv_reg) begin
                    scan_next  = '0;
                    hi_next    = n_reg - 1'b1;
                    state_next = ST_SCAN_L;
                end
            end
            // look upward for a right-class element below hi
            ST_SCAN_L: begin
                if (rv_reg && !rd_class) begin
                    lo_next      = tag_reg;
                    lo_data_next = rd_data;
                    scan_next    = hi_reg;
                    state_next   = ST_SCAN_R;
                end else if (scan_reg < hi_reg) begin
                    rd_en     = 1'b1;
                    rv_next   = 1'b1;
                    tag_next  = scan_reg;
                    scan_next = scan_reg + 1'b1;
                end else if (!rv_reg) begin
                    state_next = ST_DONE;
                end
            end
            // look downward for a left-class element above lo
            ST_SCAN_R: begin
                if (rv_reg && rd_class) begin
                    hi_next    = tag_reg;
                    wr_en      = 1'b1;
                    wr_addr    = AW'(lo_reg);
                    wr_data    = rd_data;
                    state_next = ST_SWAP;
                end else if (scan_reg > lo_reg) begin
                    rd_en     = 1'b1;
                    rv_next   = 1'b1;
                    tag_next  = scan_reg;
                    scan_next = scan_reg - 1'b1;
                end else if (!rv_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_SWAP: begin
                wr_en      = 1'b1;
                wr_addr    = AW'(hi_reg);
                wr_data    = lo_data_reg;
                scan_next  = lo_reg + 1'b1;
                hi_next    = hi_reg - 1'b1;
                state_next = ST_SCAN_L;
            end
            ST_DONE: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge aclk) begin
        tag_reg     <= tag_next;
        scan_reg    <= scan_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        n_reg       <= n_next;
        acc_reg     <= acc_next;
        lo_data_reg <= lo_data_next;
    end

    assign left_count = acc_reg;
    assign stat       = '{busy: (state_reg != ST_IDLE), done: (state_reg == ST_DONE)};

endmodule

// File: rtl/min_swap_array_partition_top.sv
// Write and read: one transfer per cycle while the pending slot can take it; the result
// passes through the pending slot and then the output register. Partition of n entries:
// a counting pass over the memory read port, then a two-pointer scan with a swap for each
// misplaced pair, then a done state; the count takes the same path. No new transfer is taken meanwhile.
// Reset (aresetn, synchronous, active low) clears the handshake and sequencer state;
// the element memory is not cleared and holds no defined data until written.
module min_swap_array_partition_top #(
    parameter int DEPTH       = msap_pkg::DEPTH_DEFAULT,
    parameter int VALUE_WIDTH = msap_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  msap_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output msap_pkg::out_item_t m_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > msap_pkg::COUNT_W) ? CW : msap_pkg::COUNT_W;

    typedef enum logic [2:0] {
        PK_ZERO = 3'b001,
        PK_READ = 3'b010,
        PK_CNT  = 3'b100
    } pend_kind_t;

    logic                       pend_valid_reg, pend_valid_next;
    pend_kind_t                 pend_kind_reg, pend_kind_next;
    logic [msap_pkg::COUNT_W-1:0] pend_cnt_reg, pend_cnt_next;
    logic                       m_valid_reg, m_valid_next;
    msap_pkg::out_item_t        m_data_reg, m_data_next;

    logic                  accept, pend_move, in_range, is_read, is_write, is_part;
    logic [XW-1:0]         count_x, n_sat;
    logic [CW-1:0]         part_n;
    logic [VALUE_WIDTH:0]  rd_data;

    logic                  mem_we, mem_re;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [VALUE_WIDTH:0]  mem_wdata;

    logic                  sw_rd_en, sw_wr_en;
    logic [AW-1:0]         sw_rd_addr, sw_wr_addr;
    logic [VALUE_WIDTH:0]  sw_wr_data;
    logic [CW-1:0]         sw_left_count;
    msap_pkg::sweep_stat_t sw_stat;

    assign pend_move = pend_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !sw_stat.busy && (!pend_valid_reg || pend_move);
    assign accept    = s_valid && s_ready;

    assign in_range = (XW'(s_data.index) < XW'(DEPTH));
    assign is_write = (s_data.opcode == msap_pkg::OP_WRITE);
    assign is_read  = (s_data.opcode == msap_pkg::OP_READ);
    assign is_part  = (s_data.opcode == msap_pkg::OP_PARTITION);

    assign count_x = XW'(s_data.count);
    assign n_sat   = (count_x > XW'(DEPTH)) ? XW'(DEPTH) : count_x;
    assign part_n  = CW'(n_sat);

    // memory ports belong to the sequencer while it runs
    always_comb begin
        if (sw_stat.busy) begin
            mem_we    = sw_wr_en;
            mem_waddr = sw_wr_addr;
            mem_wdata = sw_wr_data;
            mem_re    = sw_rd_en;
            mem_raddr = sw_rd_addr;
        end else begin
            mem_we    = accept && is_write && in_range;
            mem_waddr = AW'(s_data.index);
            mem_wdata = {s_data.goes_left, VALUE_WIDTH'(s_data.value)};
            mem_re    = accept && is_read && in_range;
            mem_raddr = AW'(s_data.index);
        end
    end

    msap_mem #(
        .DEPTH (DEPTH),
        .WIDTH (VALUE_WIDTH + 1)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (rd_data)
    );

    msap_sweep #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_sweep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (accept && is_part),
        .n          (part_n),
        .rd_data    (rd_data),
        .rd_en      (sw_rd_en),
        .rd_addr    (sw_rd_addr),
        .wr_en      (sw_wr_en),
        .wr_addr    (sw_wr_addr),
        .wr_data    (sw_wr_data),
        .left_count (sw_left_count),
        .stat       (sw_stat)
    );

    // pending slot: read data shows up in the cycle after the memory access
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_cnt_next   = pend_cnt_reg;
        if (pend_move) begin
            pend_valid_next = 1'b0;
        end
        if (accept && !is_part) begin
            pend_valid_next = 1'b1;
            pend_kind_next  = (is_read && in_range) ? PK_READ : PK_ZERO;
        end else if (sw_stat.done) begin
            pend_valid_next = 1'b1;
            pend_kind_next  = PK_CNT;
            pend_cnt_next   = msap_pkg::COUNT_W'(sw_left_count);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (pend_move) begin
            m_valid_next = 1'b1;
            m_data_next  = '0;
            unique case (pend_kind_reg)
                PK_READ: begin
                    m_data_next.read_value     = msap_pkg::VALUE_W'(rd_data[VALUE_WIDTH-1:0]);
                    m_data_next.read_goes_left = rd_data[VALUE_WIDTH];
                end
                PK_CNT: begin
                    m_data_next.left_count = pend_cnt_reg;
                end
                default: begin
                    m_data_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_kind_reg <= pend_kind_next;
        pend_cnt_reg  <= pend_cnt_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
